### design/erpm_pkg.sv
package erpm_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned RPM_W   = 16;

  localparam int unsigned MUL_A_W = 16;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_A_W);

  localparam int unsigned QUOT_W  = RPM_W - 1;
  localparam int unsigned DIV_IN_W = PROD_W + 1;
  localparam int unsigned DIV_W   = DIV_IN_W + QUOT_W;
  localparam int unsigned DIV_CNT_W = $clog2(QUOT_W + 1);

  localparam logic [MUL_A_W-1:0] RPM_SCALE = MUL_A_W'(15000);
  localparam logic [QUOT_W-1:0]  RPM_LIMIT = {QUOT_W{1'b1}};

  localparam logic [CFG_W-1:0] PPR_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] MIN_RESET = CFG_W'(10);

  typedef enum logic [IDX_W-1:0] {
    CFG_PPR = 2'd0,
    CFG_MIN = 2'd1,
    CFG_INV = 2'd2
  } cfg_idx_e;

endpackage

### design/encoder_rpm_estimator_top.sv
// Speed estimator for a quadrature encoder. Each query beat carries a millisecond timestamp,
// the x4 count and the direction, and yields one result beat with a signed rpm, a sampled
// flag and a saturated flag. A query is taken only when the block is idle; one that arrives
// sooner than the minimum interval after the stored sample goes straight to the result, as does one
// with no motion, no pulses per revolution or no elapsed time, while a full estimate runs
// two 16-step serial shift-add multiplications and then a 16-step restoring division.
// A saturating estimate ends the division after its first step. The result waits in an
// output register, so a new query may be taken while the previous result is still stalled.
// Configuration writes are taken while idle.
module encoder_rpm_estimator_top
  import erpm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TIME_W-1:0]       now_ms_i,
  input  logic [COUNT_W-1:0]      count_now_i,
  input  logic                    counting_down_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RPM_W-1:0] rpm_o,
  output logic                    sampled_o,
  output logic                    saturated_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIFF  = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_MULN  = 7'b0001000,
    ST_MULD  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   ppr_q, ppr_d;
  logic [CFG_W-1:0]   min_q, min_d;
  logic               inv_q, inv_d;
  logic [COUNT_W-1:0] prev_count_q, prev_count_d;
  logic [TIME_W-1:0]  prev_time_q, prev_time_d;

  logic [TIME_W-1:0]  now_q, now_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               down_q, down_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [COUNT_W-1:0] delta_q, delta_d;
  logic [PROD_W-1:0]  num_q, num_d;

  logic [QUOT_W-1:0]  mag_q, mag_d;
  logic               smp_q, smp_d;
  logic               sat_q, sat_d;

  logic               out_valid_q, out_valid_d;
  logic [RPM_W-1:0]   rpm_q, rpm_d;
  logic               out_smp_q, out_smp_d;
  logic               out_sat_q, out_sat_d;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;

  logic                div_start;
  logic [DIV_IN_W-1:0] div_num;
  logic [DIV_IN_W-1:0] div_den;
  logic                div_done;
  logic                div_sat;
  logic [QUOT_W-1:0]   div_quot;

  logic [COUNT_W-1:0] delta_mag;
  logic [RPM_W-1:0]   mag_ext;

  assign delta_mag = delta_q[COUNT_W-1] ? (~delta_q + COUNT_W'(1)) : delta_q;
  assign mag_ext   = RPM_W'(mag_q);
  assign div_num   = {num_q, 1'b0} + DIV_IN_W'(mul_prod);
  assign div_den   = {mul_prod, 1'b0};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    ppr_d = ppr_q;
    min_d = min_q;
    inv_d = inv_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PPR: ppr_d = cfg_data_i;
        CFG_MIN: min_d = cfg_data_i;
        CFG_INV: inv_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    prev_count_d = prev_count_q;
    prev_time_d  = prev_time_q;
    now_d        = now_q;
    cnt_d        = cnt_q;
    down_d       = down_q;
    elapsed_d    = elapsed_q;
    delta_d      = delta_q;
    num_d        = num_q;
    mag_d        = mag_q;
    smp_d        = smp_q;
    sat_d        = sat_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rpm_d        = rpm_q;
    out_smp_d    = out_smp_q;
    out_sat_d    = out_sat_q;
    mul_start    = 1'b0;
    mul_a        = RPM_SCALE;
    mul_b        = delta_mag;
    div_start    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = now_ms_i;
          cnt_d   = count_now_i;
          down_d  = counting_down_i;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        elapsed_d = now_q - prev_time_q;
        delta_d   = cnt_q - prev_count_q;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        mag_d = '0;
        sat_d = 1'b0;
        if (elapsed_q < TIME_W'(min_q)) begin
          smp_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          smp_d        = 1'b1;
          prev_count_d = cnt_q;
          prev_time_d  = now_q;
          if ((delta_q == '0) || (ppr_q == '0) || (elapsed_q == '0)) begin
            state_d = ST_DONE;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_MULN;
          end
        end
      end
      ST_MULN: begin
        mul_a = ppr_q;
        mul_b = elapsed_q;
        if (mul_done) begin
          num_d     = mul_prod;
          mul_start = 1'b1;
          state_d   = ST_MULD;
        end
      end
      ST_MULD: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sat_d   = div_sat;
          mag_d   = div_sat ? RPM_LIMIT : div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          rpm_d       = (down_q ^ inv_q) ? (~mag_ext + RPM_W'(1)) : mag_ext;
          out_smp_d   = smp_q;
          out_sat_d   = sat_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ppr_q        <= PPR_RESET;
      min_q        <= MIN_RESET;
      inv_q        <= 1'b0;
      prev_count_q <= '0;
      prev_time_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ppr_q        <= ppr_d;
      min_q        <= min_d;
      inv_q        <= inv_d;
      prev_count_q <= prev_count_d;
      prev_time_q  <= prev_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    cnt_q     <= cnt_d;
    down_q    <= down_d;
    elapsed_q <= elapsed_d;
    delta_q   <= delta_d;
    num_q     <= num_d;
    mag_q     <= mag_d;
    smp_q     <= smp_d;
    sat_q     <= sat_d;
    rpm_q     <= rpm_d;
    out_smp_q <= out_smp_d;
    out_sat_q <= out_sat_d;
  end

  erpm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  erpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .sat_o   (div_sat),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign rpm_o       = rpm_q;
  assign sampled_o   = out_smp_q;
  assign saturated_o = out_sat_q;

endmodule

### design/erpm_mul.sv
module erpm_mul
  import erpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [PROD_W-1:0]  prod_o
);

  logic [MUL_A_W-1:0]   a_q, a_d;
  logic [PROD_W-1:0]    b_q, b_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = PROD_W'(b_i);
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_q[0]) begin
        acc_d = acc_q + b_q;
      end
      a_d   = a_q >> 1;
      b_d   = b_q << 1;
      cnt_d = cnt_q + MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(MUL_A_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### design/erpm_div.sv
module erpm_div
  import erpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_IN_W-1:0] num_i,
  input  logic [DIV_IN_W-1:0] den_i,
  output logic                done_o,
  output logic                sat_o,
  output logic [QUOT_W-1:0]   quot_o
);

  logic [DIV_W-1:0]     r_q, r_d;
  logic [DIV_W-1:0]     ds_q, ds_d;
  logic [QUOT_W-1:0]    q_q, q_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 sat_q, sat_d;
  logic                 ge;

  assign ge = (r_q >= ds_q);

  always_comb begin
    r_d    = r_q;
    ds_d   = ds_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = DIV_W'(num_i);
      ds_d   = {den_i, {QUOT_W{1'b0}}};
      q_d    = '0;
      cnt_d  = '0;
      sat_d  = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        if (ge) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          ds_d  = ds_q >> 1;
          cnt_d = cnt_q + DIV_CNT_W'(1);
        end
      end else begin
        if (ge) begin
          r_d = r_q - ds_q;
        end
        q_d   = {q_q[QUOT_W-2:0], ge};
        ds_d  = ds_q >> 1;
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(QUOT_W)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    ds_q  <= ds_d;
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quot_o = q_q;

endmodule

### design/erpm_chk.sv
module erpm_chk
  import erpm_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [RPM_W-1:0] rpm_o,
  input logic                    sampled_o,
  input logic                    saturated_o
);

  localparam logic [RPM_W-1:0] POS_LIMIT = RPM_W'(RPM_LIMIT);
  localparam logic [RPM_W-1:0] NEG_LIMIT = ~POS_LIMIT + RPM_W'(1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("query beat taken while another is in flight");

  a_sat_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> sampled_o)
    else $error("saturation reported without a sample");

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sampled_o |-> rpm_o == '0)
    else $error("speed reported without a sample");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (rpm_o == POS_LIMIT) || (rpm_o == NEG_LIMIT))
    else $error("saturated speed is not at the limit");

endmodule

bind encoder_rpm_estimator_top erpm_chk u_erpm_chk (.*);
